// ----- src/ihc_pkg.sv -----
package ihc_pkg;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_IPV4    = 3'd1,
        ST_IHL_LONG    = 3'd2,
        ST_TOTLEN_SHORT = 3'd3,
        ST_BAD_PROTO   = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    // header byte offsets
    localparam logic [15:0] OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] OFS_TOTLEN_HI = 16'd2;
    localparam logic [15:0] OFS_TOTLEN_LO = 16'd3;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_CKSUM_HI  = 16'd10;
    localparam logic [15:0] OFS_CKSUM_LO  = 16'd11;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [15:0] WORD_MASK     = 16'hffff;
    localparam logic [7:0]  PROTO_RESET   = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] header_length;
        logic       checksum_ok;
    } out_item_t;

    // fields of one finished packet, handed from parser to result stage
    typedef struct packed {
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol_number;
        logic [15:0] received_checksum;
        logic [20:0] sum;
        logic [15:0] rx_length;
    } pkt_summary_t;

endpackage

// ----- src/ipv4_header_checker_top.sv -----
// IPv4 header checker. Packet bytes enter one per transfer on s_data, starting
// at the first header byte, with last_byte set on the final byte. One result
// leaves on m_data per packet: status of the first failed check (truncated
// below 20 bytes, version, IHL against received length, total length against
// received length, protocol against cfg_data), IHL*4 in bytes, and a checksum
// match flag that is set only on an ok status. Received lengths saturate at
// 65535. The block takes one byte every cycle with no gaps between packets
// while the result path does not stall it; the transfer of the last byte
// loads a packet summary register, which then loads the result register that
// drives m_data. Write the protocol register (reset value 1) only while no
// packet is in flight.
module ipv4_header_checker_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ihc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ihc_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import ihc_pkg::*;

    logic         proto_valid;
    logic         proto_ready;
    pkt_summary_t proto_summary;
    logic [7:0]   exp_proto_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_proto_reg <= PROTO_RESET;
        end else if (cfg_valid) begin
            exp_proto_reg <= cfg_data;
        end
    end

    ihc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .sum_valid (proto_valid),
        .sum_ready (proto_ready),
        .sum_data  (proto_summary)
    );

    ihc_result u_result (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .expected_protocol (exp_proto_reg),
        .sum_valid         (proto_valid),
        .sum_ready         (proto_ready),
        .sum_data          (proto_summary),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data)
    );

endmodule

// ----- src/ihc_parser.sv -----
module ihc_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ihc_pkg::in_item_t     s_data,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output ihc_pkg::pkt_summary_t sum_data
);
    import ihc_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [20:0] sum_acc_reg, sum_acc_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [15:0] rx_cksum_reg, rx_cksum_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic        sum_valid_reg, sum_valid_next;
    pkt_summary_t sum_data_reg;

    logic [15:0] idx;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [5:0]  hl;
    logic        accept;

    assign s_ready = !sum_valid_reg || sum_ready;
    assign accept  = s_valid && s_ready;
    assign idx     = byte_count_reg;
    assign b       = s_data.data_byte;

    always_comb begin
        version_ihl_next  = version_ihl_reg;
        total_length_next = total_length_reg;
        protocol_next     = protocol_reg;
        rx_cksum_next     = rx_cksum_reg;
        high_byte_next    = high_byte_reg;
        sum_acc_next      = sum_acc_reg;

        // field capture
        if (idx == OFS_VER_IHL) begin
            version_ihl_next = b;
        end else if (idx == OFS_TOTLEN_HI) begin
            total_length_next = {b, total_length_reg[7:0]};
        end else if (idx == OFS_TOTLEN_LO) begin
            total_length_next = {total_length_reg[15:8], b};
        end else if (idx == OFS_PROTO) begin
            protocol_next = b;
        end else if (idx == OFS_CKSUM_HI) begin
            rx_cksum_next = {b, rx_cksum_reg[7:0]};
        end else if (idx == OFS_CKSUM_LO) begin
            rx_cksum_next = {rx_cksum_reg[15:8], b};
        end

        hl = {version_ihl_next[3:0], 2'b00};

        // checksum field summed as zero
        v = (idx == OFS_CKSUM_HI || idx == OFS_CKSUM_LO) ? 8'd0 : b;
        if (!idx[0]) begin
            high_byte_next = v;
        end else if (idx < {10'd0, hl}) begin
            sum_acc_next = sum_acc_reg + {5'd0, high_byte_reg, v};
        end

        byte_count_next = (byte_count_reg == WORD_MASK) ? byte_count_reg
                                                        : byte_count_reg + 16'd1;
    end

    always_comb begin
        sum_valid_next = sum_valid_reg;
        if (sum_ready) begin
            sum_valid_next = 1'b0;
        end
        if (accept && s_data.last_byte) begin
            sum_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            sum_acc_reg      <= '0;
            version_ihl_reg  <= '0;
            total_length_reg <= '0;
            protocol_reg     <= '0;
            rx_cksum_reg     <= '0;
            high_byte_reg    <= '0;
            sum_valid_reg    <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            if (accept) begin
                if (s_data.last_byte) begin
                    // start over for the next packet
                    byte_count_reg   <= '0;
                    sum_acc_reg      <= '0;
                    version_ihl_reg  <= '0;
                    total_length_reg <= '0;
                    protocol_reg     <= '0;
                    rx_cksum_reg     <= '0;
                    high_byte_reg    <= '0;
                end else begin
                    byte_count_reg   <= byte_count_next;
                    sum_acc_reg      <= sum_acc_next;
                    version_ihl_reg  <= version_ihl_next;
                    total_length_reg <= total_length_next;
                    protocol_reg     <= protocol_next;
                    rx_cksum_reg     <= rx_cksum_next;
                    high_byte_reg    <= high_byte_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.last_byte) begin
            sum_data_reg.version_ihl       <= version_ihl_next;
            sum_data_reg.total_length      <= total_length_next;
            sum_data_reg.protocol_number   <= protocol_next;
            sum_data_reg.received_checksum <= rx_cksum_next;
            sum_data_reg.sum               <= sum_acc_next;
            sum_data_reg.rx_length         <= byte_count_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_data  = sum_data_reg;

endmodule

// ----- src/ihc_result.sv -----
module ihc_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            expected_protocol,
    input  logic                  sum_valid,
    output logic                  sum_ready,
    input  ihc_pkg::pkt_summary_t sum_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ihc_pkg::out_item_t    m_data
);
    import ihc_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] cksum;
    logic [5:0]  hl;
    logic        accept;

    assign sum_ready = !m_valid_reg || m_ready;
    assign accept    = sum_valid && sum_ready;

    always_comb begin
        hl    = {sum_data.version_ihl[3:0], 2'b00};
        fold1 = {1'b0, sum_data.sum[15:0]} + {12'd0, sum_data.sum[20:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        cksum = ~fold2;

        priority if (sum_data.rx_length < MIN_HDR_BYTES) begin
            m_data_next.status = ST_TRUNCATED;
        end else if (sum_data.version_ihl[7:4] != IP_VERSION) begin
            m_data_next.status = ST_NOT_IPV4;
        end else if ({10'd0, hl} > sum_data.rx_length) begin
            m_data_next.status = ST_IHL_LONG;
        end else if (sum_data.total_length < sum_data.rx_length) begin
            m_data_next.status = ST_TOTLEN_SHORT;
        end else if (sum_data.protocol_number != expected_protocol) begin
            m_data_next.status = ST_BAD_PROTO;
        end else begin
            m_data_next.status = ST_OK;
        end

        m_data_next.header_length = hl;
        m_data_next.checksum_ok   = (m_data_next.status == ST_OK) &&
                                    (cksum == sum_data.received_checksum);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
